// ===== hdl/bba_pkg.sv =====
// Package for the bitmap block allocator: sizes, operation, status and
// register codes, the search result struct and the shared helper functions.
// Depends on nothing; bba_word_search and the top level use it.
`default_nettype none

package bba_pkg;

   localparam int ENTRIES = 256;
   localparam int WORD_W  = 32;
   localparam int BIT_W   = 5;
   localparam int WORDS   = (ENTRIES + WORD_W - 1) / WORD_W;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int POS_W   = $clog2(ENTRIES);
   localparam int LIM_W   = $clog2(ENTRIES + 1);

   localparam int NUM_W  = 9;
   localparam int OP_W   = 2;
   localparam int STS_W  = 2;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 9;

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_ENTRY_LIMIT    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_RESERVED_COUNT = 2'd1;

   typedef struct packed {
      logic              found;
      logic [BIT_W-1:0]  bit_idx;
      logic [WORD_W-1:0] onehot;
   } srch_type;

   // Saturate a register value at the store size.
   function automatic logic [LIM_W-1:0] clamp_entries(input logic [CSR_DW-1:0] v);
      logic [LIM_W-1:0] r;
      if (32'(v) > 32'(ENTRIES)) r = LIM_W'(ENTRIES);
      else r = LIM_W'(v);
      return r;
   endfunction

   // Bits of one word whose entry positions lie below count.
   function automatic logic [WORD_W-1:0] word_mask(input logic [LIM_W-1:0]   count,
                                                   input logic [WORD_AW-1:0] word);
      logic [31:0]       cnt;
      logic [31:0]       base;
      logic [31:0]       diff;
      logic [WORD_W-1:0] m;
      cnt  = 32'(count);
      base = 32'(word) << BIT_W;
      diff = cnt - base;
      if (cnt >= base + 32'(WORD_W)) m = '1;
      else if (cnt > base) m = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
      else m = '0;
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bba_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the usage bitmap store; no package dependency.
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bba_word_search.sv =====
// Lowest-clear-bit search over one bitmap word, restricted to usable bits.
// Depends on bba_pkg for the word width and the search result struct.
`default_nettype none

module bba_word_search (
   input  logic [bba_pkg::WORD_W-1:0] word,
   input  logic [bba_pkg::WORD_W-1:0] usable,
   output bba_pkg::srch_type          result
);

   logic [bba_pkg::WORD_W-1:0] clear_bits;
   logic [bba_pkg::WORD_W-1:0] lowest;
   logic [bba_pkg::BIT_W-1:0]  idx;

   // Two's complement trick isolates the lowest set bit of clear_bits.
   assign clear_bits = ~word & usable;
   assign lowest     = clear_bits & (~clear_bits + bba_pkg::WORD_W'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < bba_pkg::WORD_W; i++) begin
         if (lowest[i]) idx = idx | bba_pkg::BIT_W'(i);
      end
   end

   assign result.found   = |clear_bits;
   assign result.bit_idx = idx;
   assign result.onehot  = lowest;

endmodule

`default_nettype wire

// ===== hdl/bitmap_block_allocator_unit.sv =====
// Top level of the bitmap block allocator: control sequencer, register file
// and output register. Depends on bba_pkg, bba_ram and bba_word_search.
`default_nettype none

// Usage:
// A request transaction (req_operation, req_index) asks to allocate, free or
// format. Each request gives exactly one response transaction (rsp_granted,
// rsp_status). The usage bitmap lives in a one-read, one-write RAM of 32-bit
// words; allocate and free read, modify and write back those words, while
// format only writes them. Allocate reads the words in order, one per cycle,
// overlapping the next read with the search of the current word: it checks
// up to 8 words and then goes to the finish step, which loads the response.
// Free takes one read and one write-back before it finishes; an index out of
// range goes straight to the finish step. Format writes every word once (8
// writes) and then finishes. req_ready returns in the same cycle as the
// loaded response appears at the outputs, with rsp_valid high.
// One request is in work at a time; the RAM read port sets that sequence.
// A finished response sits in an output register, so the next request is
// accepted while the receiver stalls; its result then waits in the sequencer
// until the output register drains, and req_ready stays low meanwhile.
// Reset is synchronous: it restores entry_limit to 256 and reserved_count to
// 1 and clears one valid flag per word, so the whole bitmap reads as empty at
// once without a clearing pass. The user must write registers through csr_wr_en
// only while no transaction is in work; the block does not enforce this.

module bitmap_block_allocator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bba_pkg::OP_W-1:0]     req_operation,
   input  logic [bba_pkg::NUM_W-1:0]    req_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bba_pkg::NUM_W-1:0]    rsp_granted,
   output logic [bba_pkg::STS_W-1:0]    rsp_status,
   input  logic                         csr_wr_en,
   input  logic [bba_pkg::CSR_AW-1:0]   csr_index,
   input  logic [bba_pkg::CSR_DW-1:0]   csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_FREE   = 5'b00100,
      ST_FORMAT = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic [bba_pkg::WORD_AW-1:0] LAST_WORD = bba_pkg::WORD_AW'(bba_pkg::WORDS - 1);

   state_type                       state_ff, state_in;
   logic [bba_pkg::LIM_W-1:0]       limit_ff;
   logic [bba_pkg::LIM_W-1:0]       reserved_ff;
   logic [bba_pkg::WORDS-1:0]       vld_ff;
   logic                            rd_vld_ff;
   logic [bba_pkg::WORD_AW-1:0]     word_ff, word_in;
   logic [bba_pkg::POS_W-1:0]       pos_ff;
   logic [bba_pkg::NUM_W-1:0]       res_granted_ff, res_granted_in;
   logic [bba_pkg::STS_W-1:0]       res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::NUM_W-1:0]       rsp_granted_ff;
   logic [bba_pkg::STS_W-1:0]       rsp_status_ff;

   logic                            req_fire;
   logic                            load_rsp;
   logic                            free_ok;
   logic [bba_pkg::POS_W-1:0]       free_pos;
   logic [bba_pkg::POS_W-1:0]       grant_pos;
   logic [bba_pkg::POS_W:0]         grant_num;

   logic                            rd_en;
   logic [bba_pkg::WORD_AW-1:0]     rd_addr;
   logic [bba_pkg::WORD_W-1:0]      rd_data;
   logic [bba_pkg::WORD_W-1:0]      eff_word;
   logic                            wr_en;
   logic [bba_pkg::WORD_AW-1:0]     wr_addr;
   logic [bba_pkg::WORD_W-1:0]      wr_data;
   bba_pkg::srch_type               srch;

   bba_ram #(
      .WIDTH (bba_pkg::WORD_W),
      .DEPTH (bba_pkg::WORDS)
   ) u_usage_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A word never written since reset reads as all clear.
   assign eff_word = rd_vld_ff ? rd_data : '0;

   bba_word_search u_search (
      .word   (eff_word),
      .usable (bba_pkg::word_mask(limit_ff, word_ff)),
      .result (srch)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign free_ok  = (req_index != '0) && (32'(req_index) <= 32'(limit_ff));
   assign free_pos = bba_pkg::POS_W'(req_index - bba_pkg::NUM_W'(1));

   assign grant_pos = bba_pkg::POS_W'({word_ff, srch.bit_idx});
   assign grant_num = {1'b0, grant_pos} + (bba_pkg::POS_W + 1)'(1);

   always_comb begin
      state_in       = state_ff;
      word_in        = word_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      rd_en          = 1'b0;
      rd_addr        = word_ff;
      wr_en          = 1'b0;
      wr_addr        = word_ff;
      wr_data        = eff_word;
      load_rsp       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_granted_in = '0;
               res_status_in  = bba_pkg::STS_OK;
               word_in        = '0;
               unique case (req_operation)
                  bba_pkg::OP_ALLOC: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_SCAN;
                  end
                  bba_pkg::OP_FREE: begin
                     if (free_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = bba_pkg::WORD_AW'(free_pos >> bba_pkg::BIT_W);
                        state_in = ST_FREE;
                     end else begin
                        res_status_in = bba_pkg::STS_RANGE;
                        state_in      = ST_FINISH;
                     end
                  end
                  bba_pkg::OP_FORMAT: begin
                     state_in = ST_FORMAT;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // word_ff data is here; the next word is read if the scan goes on.
            if (srch.found) begin
               wr_en          = 1'b1;
               wr_data        = eff_word | srch.onehot;
               res_granted_in = bba_pkg::NUM_W'(grant_num);
               state_in       = ST_FINISH;
            end else if (word_ff == LAST_WORD) begin
               res_status_in = bba_pkg::STS_FULL;
               state_in      = ST_FINISH;
            end else begin
               word_in = word_ff + bba_pkg::WORD_AW'(1);
               rd_en   = 1'b1;
               rd_addr = word_ff + bba_pkg::WORD_AW'(1);
            end
         end
         ST_FREE: begin
            wr_en    = 1'b1;
            wr_addr  = bba_pkg::WORD_AW'(pos_ff >> bba_pkg::BIT_W);
            wr_data  = eff_word & ~(bba_pkg::WORD_W'(1) << pos_ff[bba_pkg::BIT_W-1:0]);
            state_in = ST_FINISH;
         end
         ST_FORMAT: begin
            wr_en   = 1'b1;
            wr_data = bba_pkg::word_mask(reserved_ff, word_ff);
            if (word_ff == LAST_WORD) begin
               state_in = ST_FINISH;
            end else begin
               word_in = word_ff + bba_pkg::WORD_AW'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= bba_pkg::clamp_entries(bba_pkg::CSR_DW'(256));
         reserved_ff  <= bba_pkg::clamp_entries(bba_pkg::CSR_DW'(1));
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (csr_wr_en) begin
            if (csr_index == bba_pkg::CSR_ENTRY_LIMIT) begin
               limit_ff <= bba_pkg::clamp_entries(csr_wr_data);
            end else if (csr_index == bba_pkg::CSR_RESERVED_COUNT) begin
               reserved_ff <= bba_pkg::clamp_entries(csr_wr_data);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      if (rd_en) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
      if (req_fire) begin
         pos_ff <= free_pos;
      end
      if (load_rsp) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_status  = rsp_status_ff;

   // The bitmap is written only while a transaction is in work.
   a_write_in_work: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_FREE || state_ff == ST_FORMAT))
      else $error("bitmap written outside of an operation");

   // A new response only comes out of the finish step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised without a finished operation");

   // A full status never carries an entry number.
   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bba_pkg::STS_FULL) |-> (rsp_granted_ff == '0))
      else $error("full status with a granted entry");

   // A granted entry lies within the configured limit.
   a_grant_in_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff != '0) |-> (32'(rsp_granted_ff) <= 32'(limit_ff)))
      else $error("granted entry beyond the limit");

endmodule

`default_nettype wire
